FILE: design/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// S-box table, round helpers and shared types for the key-stream encryptor.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned BlockW  = 128;
  localparam int unsigned HalfW   = 64;
  localparam int unsigned Rounds  = 10;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned QDepth  = 4;

  localparam logic [CfgIdxW-1:0] RegPtHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegPtLow  = 1'b1;

  typedef logic [BlockW-1:0] block_t;

  // Key and state travel together down the round pipeline.
  typedef struct packed {
    block_t state;
    block_t rkey;
  } round_data_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Round constant for round n (1..10), counted from 0x01.
  function automatic logic [7:0] rcon(input int unsigned n);
    logic [7:0] r;
    r = 8'h01;
    for (int unsigned i = 1; i < 10; i++) begin
      if (i < n) r = xtime(r);
    end
    return r;
  endfunction

  // Byte i of a block, byte 0 in the top bits.
  function automatic logic [7:0] byte_of(input block_t b, input int unsigned i);
    return b[BlockW-1-8*i -: 8];
  endfunction

  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    logic [7:0] kb [16];
    logic [7:0] t [4];
    block_t o;
    for (int unsigned i = 0; i < 16; i++) kb[i] = byte_of(k, i);
    t[0] = sbox(kb[13]) ^ rc;
    t[1] = sbox(kb[14]);
    t[2] = sbox(kb[15]);
    t[3] = sbox(kb[12]);
    for (int unsigned i = 0; i < 4; i++) kb[i] = kb[i] ^ t[i];
    for (int unsigned i = 4; i < 16; i++) kb[i] = kb[i] ^ kb[i-4];
    for (int unsigned i = 0; i < 16; i++) o[BlockW-1-8*i -: 8] = kb[i];
    return o;
  endfunction

  // SubBytes, ShiftRows and optionally MixColumns.
  function automatic block_t round_fn(input block_t s, input logic mix);
    logic [7:0] sb [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    block_t o;
    for (int unsigned i = 0; i < 16; i++) sb[i] = byte_of(s, i);
    for (int unsigned c = 0; c < 4; c++) begin
      for (int unsigned r = 0; r < 4; r++) begin
        t[r + 4*c] = sbox(sb[r + 4*((c + r) % 4)]);
      end
    end
    if (mix) begin
      for (int unsigned c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int unsigned i = 0; i < 16; i++) o[BlockW-1-8*i -: 8] = t[i];
    return o;
  endfunction

endpackage

FILE: design/aes_front.sv
// ----------------------------------------------------------------------------
// AES front end
// Holds the plaintext registers and takes each key item, applying the
// initial AddRoundKey into a registered output stage.
// ----------------------------------------------------------------------------
module aes_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [aes_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [aes_pkg::HalfW-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  aes_pkg::block_t              in_key,
  output logic                         f_valid,
  input  logic                         f_ready,
  output aes_pkg::round_data_t         f_data
);
  import aes_pkg::*;

  logic [HalfW-1:0] pt_hi_r, pt_lo_r;
  logic             vld_r;
  round_data_t      data_r;

  // Plaintext registers; only two indexes exist.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_hi_r <= '0;
      pt_lo_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegPtHigh: pt_hi_r <= cfg_wdata;
        RegPtLow:  pt_lo_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = !vld_r || f_ready;

  // Output stage carries the whitened state and the cipher key.
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (in_ready) vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r.state <= {pt_hi_r, pt_lo_r} ^ in_key;
      data_r.rkey  <= in_key;
    end
  end

  assign f_valid = vld_r;
  assign f_data  = data_r;
endmodule

FILE: design/aes_queue.sv
// ----------------------------------------------------------------------------
// AES queue
// Small FIFO between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module aes_queue #(
  parameter int unsigned DEPTH = aes_pkg::QDepth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s_valid,
  output logic                  s_ready,
  input  aes_pkg::round_data_t  s_data,
  output logic                  m_valid,
  input  logic                  m_ready,
  output aes_pkg::round_data_t  m_data
);
  import aes_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  round_data_t       mem_r [DEPTH];
  logic [PtrW-1:0]   wp_r, rp_r;
  logic [PtrW:0]     cnt_r;
  logic              push, pop;

  assign s_ready = (cnt_r != (PtrW+1)'(DEPTH));
  assign m_valid = (cnt_r != '0);
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;
  assign m_data  = mem_r[rp_r];

  // Pointers wrap at the depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PtrW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PtrW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= s_data;
  end
endmodule

FILE: design/aes_rounds.sv
// ----------------------------------------------------------------------------
// AES round pipeline
// Ten unrolled rounds, one register stage per round, with the key schedule
// computed alongside. The whole pipe advances together under back pressure.
// ----------------------------------------------------------------------------
module aes_rounds (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s_valid,
  output logic                  s_ready,
  input  aes_pkg::round_data_t  s_data,
  output logic                  m_valid,
  input  logic                  m_ready,
  output aes_pkg::block_t       m_data
);
  import aes_pkg::*;

  logic        vld_r  [Rounds];
  round_data_t data_r [Rounds];
  logic        adv;

  // A stalled last stage holds the whole pipe, empty slots included.
  assign adv     = !vld_r[Rounds-1] || m_ready;
  assign s_ready = adv;

  for (genvar g = 0; g < Rounds; g++) begin : g_round
    round_data_t src;
    logic        src_v;
    block_t      nk;
    if (g == 0) begin : g_first
      assign src   = s_data;
      assign src_v = s_valid;
    end else begin : g_next
      assign src   = data_r[g-1];
      assign src_v = vld_r[g-1];
    end
    assign nk = next_key(src.rkey, rcon(g + 1));

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[g] <= 1'b0;
      else if (adv) vld_r[g] <= src_v;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        data_r[g].state <= round_fn(src.state, (g != Rounds-1)) ^ nk;
        data_r[g].rkey  <= nk;
      end
    end
  end

  assign m_valid = vld_r[Rounds-1];
  assign m_data  = data_r[Rounds-1].state;
endmodule

FILE: design/aes128_key_stream_encrypt_unit.sv
// ----------------------------------------------------------------------------
// AES-128 key-stream encryptor
// Encrypts a fixed plaintext under each incoming key.
// ----------------------------------------------------------------------------
// Usage: write plaintext bytes 0..7 to register 0 and bytes 8..15 to register
// 1 through the cfg port while the block is idle. Each item on the in_
// channel is a 128-bit key; the out_ channel returns one ciphertext item for
// it, in order.
// Throughput is one item per cycle while the receiver does not stall: the
// ten rounds are unrolled, one stage each, with the key schedule running
// beside them. An accepted key passes the input stage register, the queue
// and then the ten round registers before out_tvalid rises.
// Reset clears the plaintext to zero and empties every stage. When the
// receiver stalls, the round pipe holds and the queue absorbs up to four
// items while the front keeps accepting; then in_tready falls.
// ----------------------------------------------------------------------------
module aes128_key_stream_encrypt_unit #(
  parameter int unsigned QUEUE_DEPTH = aes_pkg::QDepth
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [aes_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [aes_pkg::HalfW-1:0]    cfg_wdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [63:0] cipher_key_high, [127:64] cipher_key_low
  input  logic [127:0]                 in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [63:0] ciphertext_high, [127:64] ciphertext_low
  output logic [127:0]                 out_tdata
);
  import aes_pkg::*;

  logic        f_valid, f_ready, q_valid, q_ready;
  round_data_t f_data, q_data;
  block_t      key, ct;

  assign key = {in_tdata[63:0], in_tdata[127:64]};

  aes_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata,
    .in_valid(in_tvalid), .in_ready(in_tready), .in_key(key),
    .f_valid, .f_ready, .f_data
  );

  aes_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .s_valid(f_valid), .s_ready(f_ready), .s_data(f_data),
    .m_valid(q_valid), .m_ready(q_ready), .m_data(q_data)
  );

  aes_rounds u_rounds (
    .clk, .rst_n,
    .s_valid(q_valid), .s_ready(q_ready), .s_data(q_data),
    .m_valid(out_tvalid), .m_ready(out_tready), .m_data(ct)
  );

  assign out_tdata = {ct[HalfW-1:0], ct[BlockW-1:HalfW]};
endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// AES-128 key-stream encryptor testbench
// Drives keys with random gaps and back-pressure, predicts each ciphertext
// from known vectors or an independent AES-128 model, and checks every result item in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandom = 500;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned Drain     = 40;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [aes_pkg::CfgIdxW-1:0] cfg_idx;
  logic [63:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;

  aes128_key_stream_encrypt_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Directed stimulus row; the ciphertext is given only when known by heart.
  typedef struct {
    logic [63:0] pt_hi, pt_lo, key_hi, key_lo;
    logic        known;
    logic [63:0] ct_hi, ct_lo;
  } key_row_t;

  logic [63:0]  pt_hi_q, pt_lo_q;
  logic [127:0] ciphertext_q[$];
  int unsigned  mismatches = 0, results_seen = 0, idle_cycles = 0;
  int unsigned  keys_sent;
  bit           timed_out = 1'b0;

  byte unsigned sb_tab[256];

  // Build the S-box from the field inverse and the affine map.
  function automatic byte unsigned gmul(byte unsigned a, byte unsigned b);
    byte unsigned p;
    p = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic byte unsigned xt(byte unsigned b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  task automatic build_sbox();
    byte unsigned inv, x;
    for (int a = 0; a < 256; a++) begin
      inv = 0;
      for (int c = 1; c < 256; c++) if (gmul(8'(a), 8'(c)) == 1) inv = 8'(c);
      x = inv;
      for (int i = 0; i < 8; i++)
        x[i] = inv[i] ^ inv[(i+4)%8] ^ inv[(i+5)%8] ^ inv[(i+6)%8] ^ inv[(i+7)%8];
      sb_tab[a] = x ^ 8'h63;
    end
  endtask

  function automatic logic [127:0] encrypt_block(logic [63:0] ph, logic [63:0] pl,
                                                 logic [63:0] kh, logic [63:0] kl);
    byte unsigned s[16], k[16], t[16], w[4];
    byte unsigned rc, a0, a1, a2, a3, al;
    logic [127:0] pt, kt, o;
    pt = {ph, pl};
    kt = {kh, kl};
    for (int i = 0; i < 16; i++) begin
      s[i] = pt[127-8*i -: 8] ^ kt[127-8*i -: 8];
      k[i] = kt[127-8*i -: 8];
    end
    rc = 8'h01;
    for (int r = 1; r <= 10; r++) begin
      w[0] = sb_tab[k[13]] ^ rc; w[1] = sb_tab[k[14]];
      w[2] = sb_tab[k[15]];      w[3] = sb_tab[k[12]];
      for (int i = 0; i < 4; i++) k[i] ^= w[i];
      for (int i = 4; i < 16; i++) k[i] ^= k[i-4];
      rc = xt(rc);
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) t[j+4*c] = sb_tab[s[j+4*((c+j)%4)]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
          t[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
          t[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
          t[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ k[i];
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
    return o;
  endfunction

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // One register write; the extra edge keeps consecutive writes apart.
  task automatic write_reg(logic [aes_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == aes_pkg::RegPtHigh) pt_hi_q = val;
    else pt_lo_q = val;
    @(posedge clk);
  endtask

  // Let the pipe empty before touching the plaintext.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (ciphertext_q.size() != 0 && !timed_out) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  // The valid stays high after acceptance so that keys can follow back to back.
  task automatic send_key(logic [63:0] kh, logic [63:0] kl, logic [127:0] expd);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {kl, kh};
    ciphertext_q.push_back(expd);
    do @(posedge clk); while (!in_tready && !timed_out);
    keys_sent++;
  endtask

  // Receiver side: random back-pressure and in-order checking.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        logic [127:0] exp_ct;
        results_seen++;
        if (ciphertext_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %h", out_tdata);
        end else begin
          exp_ct = ciphertext_q.pop_front();
          if (out_tdata[63:0] !== exp_ct[127:64] || out_tdata[127:64] !== exp_ct[63:0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ciphertext mismatch: expected hi %h lo %h, got hi %h lo %h",
                       exp_ct[127:64], exp_ct[63:0], out_tdata[63:0], out_tdata[127:64]);
          end
        end
      end
      out_tready <= ($urandom_range(0, 30) == 0) ? 1'b0 :
                    ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      timed_out = 1'b1;
      $display("tb NOT OK");
      $finish;
    end
  end

  key_row_t rows[$];

  initial begin
    logic [127:0] ct;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    pt_hi_q = '0; pt_lo_q = '0;
    keys_sent = 0;
    build_sbox();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset plaintext of zero under the zero key, then FIPS-197 vectors, then patterned operands.
    rows.push_back('{64'h0, 64'h0, 64'h0, 64'h0, 1'b1,
                     64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
    rows.push_back('{64'h0011223344556677, 64'h8899aabbccddeeff,
                     64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b1,
                     64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
    rows.push_back('{64'h3243f6a8885a308d, 64'h313198a2e0370734,
                     64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b1,
                     64'h3925841d02dc09fb, 64'hdc118597196a0b32});
    rows.push_back('{64'h0, 64'h0, '1, '1, 1'b0, '0, '0});
    rows.push_back('{'1, '1, '1, '1, 1'b0, '0, '0});
    rows.push_back('{'1, '1, 64'h0, 64'h0, 1'b0, '0, '0});
    rows.push_back('{'1, 64'h0, 64'h8000000000000000, 64'h1, 1'b0, '0, '0});
    rows.push_back('{64'h0, '1, 64'h1, 64'h8000000000000000, 1'b0, '0, '0});
    rows.push_back('{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
                     64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, '0, '0});

    // Directed part; a plaintext change waits for the pipe to empty.
    foreach (rows[i]) begin
      if (rows[i].pt_hi !== pt_hi_q || rows[i].pt_lo !== pt_lo_q) begin
        wait_idle();
        write_reg(aes_pkg::RegPtHigh, rows[i].pt_hi);
        write_reg(aes_pkg::RegPtLow, rows[i].pt_lo);
      end
      ct = rows[i].known ? {rows[i].ct_hi, rows[i].ct_lo}
                         : encrypt_block(pt_hi_q, pt_lo_q, rows[i].key_hi, rows[i].key_lo);
      send_key(rows[i].key_hi, rows[i].key_lo, ct);
    end

    // Random part in phases, each under a fresh plaintext.
    for (int ph = 0; ph < 10; ph++) begin
      logic [63:0] kh, kl;
      wait_idle();
      write_reg(aes_pkg::RegPtHigh, rand64());
      write_reg(aes_pkg::RegPtLow, rand64());
      for (int n = 0; n < NumRandom / 10; n++) begin
        kh = rand64();
        kl = rand64();
        // Once per phase the sender holds until every result is back.
        if (n == 25) begin
          in_tvalid <= 1'b0;
          while (ciphertext_q.size() != 0 && !timed_out) @(posedge clk);
        end
        send_key(kh, kl, encrypt_block(pt_hi_q, pt_lo_q, kh, kl));
      end
    end

    wait_idle();
    $display("Sent %0d keys over directed and random plaintexts, %0d ciphertexts checked.",
             keys_sent, results_seen);
    $display("Covered FIPS-197 vectors, all-zero and all-one operands and random keys.");
    if (mismatches == 0 && ciphertext_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
